// File: rtl/core/avcd_pkg.sv
package avcd_pkg;

  // result kinds, carried on m_tuser
  typedef enum logic [3:0] {
    K_AUDIO     = 4'd0,
    K_PAD       = 4'd1,
    K_HEAD      = 4'd2,
    K_BODY      = 4'd3,
    K_META      = 4'd4,
    K_SEGMENT   = 4'd5,
    K_END       = 4'd6,
    K_MAGIC_ERR = 4'd7,
    K_CODE_ERR  = 4'd8
  } kind_t;

  typedef struct packed {
    logic        last;
    logic [15:0] pic_height;
    logic [15:0] pic_width;
    logic [7:0]  audio_bits;
    logic [7:0]  audio_chans;
    logic [15:0] audio_rate;
    logic [31:0] frames;
    logic [31:0] count;
    logic [7:0]  data_byte;
    kind_t       kind;
  } res_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned OUT_DATA_W  = 136;

  // file magic, first byte in the lowest lane
  localparam logic [31:0] MAGIC     = 32'h4656_4149;
  localparam logic [7:0]  HDR_LAST  = 8'h90;

  localparam logic [7:0]  OFS_RATE_LO   = 8'h1C;
  localparam logic [7:0]  OFS_RATE_HI   = 8'h1D;
  localparam logic [7:0]  OFS_CHANS     = 8'h1E;
  localparam logic [7:0]  OFS_BITS      = 8'h1F;
  localparam logic [7:0]  OFS_HEIGHT_LO = 8'h2F;
  localparam logic [7:0]  OFS_HEIGHT_HI = 8'h30;
  localparam logic [7:0]  OFS_WIDTH_LO  = 8'h31;
  localparam logic [7:0]  OFS_WIDTH_HI  = 8'h32;

  localparam logic [31:0] VID_SKIP  = 32'h1C;
  localparam logic [31:0] VID_HEAD  = 32'h68;
  localparam logic [31:0] FRM_SKIP  = 32'h8;
  localparam logic [31:0] MISC_SKIP = 32'hC;

  localparam logic [15:0] CODE_AUDIO  = 16'h0066;
  localparam logic [15:0] CODE_VHDR   = 16'h006A;
  localparam logic [15:0] CODE_FRAME  = 16'h006C;
  localparam logic [15:0] CODE_SKIP_A = 16'h0067;
  localparam logic [15:0] CODE_SKIP_B = 16'h0068;
  localparam logic [15:0] CODE_SKIP_C = 16'h0070;
  localparam logic [15:0] CODE_SKIP_D = 16'h0075;
  localparam logic [15:0] CODE_SKIP_E = 16'h0077;
  localparam logic [15:0] CODE_SKIP_F = 16'h0079;

endpackage

// File: rtl/core/av_container_chunk_demux.sv
// Container demultiplexer: takes the file one byte per item on the slave side (s_tlast marks
// end of file, its byte ignored), checks the magic word, captures the audio and video
// parameters from the header and then splits the chunk stream into tagged audio, head and
// body bytes, pad runs, metadata, segment, end and error results on the master side.
// Each accepted byte is parsed in the cycle it is taken and its zero, one or two results are
// written into a four-entry output queue; one byte is accepted every cycle while the queue
// has two free entries, so the rate is one byte per cycle as long as the sink drains one
// result per cycle. A byte that gives two results (last audio byte with a pad run, or a code
// error with its end result) writes both into the queue at once. After an end or an error
// result no further results appear until reset.
module av_container_chunk_demux
  import avcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // in_byte
  input  logic                  s_tlast,   // end_of_file
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // data_byte, count, frames, audio_rate,
                                           // audio_chans, audio_bits, pic_width, pic_height
  output logic [3:0]            m_tuser,   // kind
  output logic                  m_tlast    // last
);

  typedef enum logic [3:0] {
    PH_HDR, PH_CODE, PH_A_IDX, PH_A_EFF, PH_A_DATA, PH_AUDIO, PH_A_SKIP,
    PH_V_SIZE, PH_V_SKIP, PH_V_HEAD, PH_F_SIZE, PH_F_SKIP, PH_BODY,
    PH_SKIP, PH_HALT
  } phase_t;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  phase_t      phase, phase_next;
  logic [7:0]  file_offset, file_offset_next;
  logic [7:0]  code_lo, code_lo_next;
  logic [1:0]  byte_idx, byte_idx_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] effective_size, effective_size_next;
  logic [31:0] payload_size, payload_size_next;
  logic [31:0] audio_total, audio_total_next;
  logic [31:0] frame_total, frame_total_next;
  logic        seen_segment, seen_segment_next;
  logic [15:0] audio_rate, audio_rate_next;
  logic [7:0]  audio_chans, audio_chans_next;
  logic [7:0]  audio_bits, audio_bits_next;
  logic [15:0] pic_width, pic_width_next;
  logic [15:0] pic_height, pic_height_next;

  res_t        r0, r1;
  logic [1:0]  n_res;

  res_t             queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             accept, pop;
  logic [1:0]       n_push;
  logic [PTR_W-1:0] wr_ptr_p1;

  logic [7:0]  b;
  logic [31:0] field_word;
  logic [15:0] code_word;
  logic [31:0] word_src;
  logic        field_done;
  logic        count_done;

  assign accept = s_tvalid && s_tready;
  assign pop    = m_tvalid && m_tready;
  assign b      = s_tdata;

  function automatic logic [31:0] set_lane(logic [31:0] w, logic [1:0] idx, logic [7:0] v);
    logic [31:0] o;
    o = w;
    unique case (idx)
      2'd0: o[7:0]   = v;
      2'd1: o[15:8]  = v;
      2'd2: o[23:16] = v;
      2'd3: o[31:24] = v;
    endcase
    return o;
  endfunction

  function automatic res_t totals(kind_t k, logic [31:0] a, logic [31:0] f);
    res_t r;
    r        = '0;
    r.kind   = k;
    r.count  = a;
    r.frames = f;
    return r;
  endfunction

  function automatic res_t byte_res(kind_t k, logic [7:0] v);
    res_t r;
    r           = '0;
    r.kind      = k;
    r.data_byte = v;
    return r;
  endfunction

  always_comb begin
    unique case (phase)
      PH_A_EFF: word_src = effective_size;
      default:  word_src = payload_size;
    endcase
  end

  assign field_word = set_lane(word_src, byte_idx, b);
  assign field_done = (byte_idx == 2'd3);
  assign code_word  = {b, code_lo};
  assign count_done = (bytes_left == 32'd1);

  always_comb begin
    phase_next          = phase;
    file_offset_next    = file_offset;
    code_lo_next        = code_lo;
    byte_idx_next       = byte_idx;
    bytes_left_next     = bytes_left;
    effective_size_next = effective_size;
    payload_size_next   = payload_size;
    audio_total_next    = audio_total;
    frame_total_next    = frame_total;
    seen_segment_next   = seen_segment;
    audio_rate_next     = audio_rate;
    audio_chans_next    = audio_chans;
    audio_bits_next     = audio_bits;
    pic_width_next      = pic_width;
    pic_height_next     = pic_height;
    r0                  = '0;
    r1                  = '0;
    n_res               = 2'd0;

    if (phase == PH_HALT) begin
      phase_next = PH_HALT;
    end else if (s_tlast) begin
      if (phase == PH_HDR && file_offset < 8'd4) begin
        r0      = '0;
        r0.kind = K_MAGIC_ERR;
      end else begin
        r0 = totals(K_END, audio_total, frame_total);
      end
      n_res      = 2'd1;
      phase_next = PH_HALT;
    end else begin
      unique case (phase)
        PH_HDR: begin
          if (file_offset < 8'd4 && b != MAGIC[file_offset[1:0]*8 +: 8]) begin
            r0         = '0;
            r0.kind    = K_MAGIC_ERR;
            n_res      = 2'd1;
            phase_next = PH_HALT;
          end else begin
            if (file_offset == OFS_RATE_LO)   audio_rate_next[7:0]  = b;
            if (file_offset == OFS_RATE_HI)   audio_rate_next[15:8] = b;
            if (file_offset == OFS_CHANS)     audio_chans_next      = b;
            if (file_offset == OFS_BITS)      audio_bits_next       = b;
            if (file_offset == OFS_HEIGHT_LO) pic_height_next[7:0]  = b;
            if (file_offset == OFS_HEIGHT_HI) pic_height_next[15:8] = b;
            if (file_offset == OFS_WIDTH_LO)  pic_width_next[7:0]   = b;
            if (file_offset == OFS_WIDTH_HI)  pic_width_next[15:8]  = b;
            if (file_offset >= HDR_LAST) begin
              r0             = '0;
              r0.kind        = K_META;
              r0.audio_rate  = audio_rate;
              r0.audio_chans = audio_chans;
              r0.audio_bits  = audio_bits;
              r0.pic_width   = pic_width;
              r0.pic_height  = pic_height;
              n_res          = 2'd1;
              phase_next     = PH_CODE;
              code_lo_next   = '0;
              byte_idx_next  = '0;
            end else begin
              file_offset_next = file_offset + 8'd1;
            end
          end
        end
        PH_CODE: begin
          if (byte_idx == 2'd0) begin
            code_lo_next  = b;
            byte_idx_next = 2'd1;
          end else begin
            byte_idx_next = '0;
            priority if (code_word == CODE_AUDIO) begin
              phase_next = PH_A_IDX;
            end else if (code_word == CODE_VHDR) begin
              if (seen_segment) begin
                r0               = totals(K_SEGMENT, audio_total, frame_total);
                n_res            = 2'd1;
                audio_total_next = '0;
              end
              frame_total_next  = '0;
              seen_segment_next = 1'b1;
              phase_next        = PH_V_SIZE;
            end else if (code_word == CODE_FRAME) begin
              frame_total_next = frame_total + 32'd1;
              phase_next       = PH_F_SIZE;
            end else if (code_word == CODE_SKIP_A || code_word == CODE_SKIP_B ||
                         code_word == CODE_SKIP_C || code_word == CODE_SKIP_D ||
                         code_word == CODE_SKIP_E || code_word == CODE_SKIP_F) begin
              phase_next      = PH_SKIP;
              bytes_left_next = MISC_SKIP;
            end else begin
              r0         = '0;
              r0.kind    = K_CODE_ERR;
              r1         = totals(K_END, audio_total, frame_total);
              n_res      = 2'd2;
              phase_next = PH_HALT;
            end
          end
        end
        PH_A_IDX: begin
          byte_idx_next = byte_idx + 2'd1;
          if (field_done) phase_next = PH_A_EFF;
        end
        PH_A_EFF: begin
          effective_size_next = field_word;
          byte_idx_next       = byte_idx + 2'd1;
          if (field_done) phase_next = PH_A_DATA;
        end
        PH_A_DATA: begin
          payload_size_next = field_word;
          byte_idx_next     = byte_idx + 2'd1;
          if (field_done) begin
            bytes_left_next = field_word;
            if (effective_size == '0) begin
              phase_next = (field_word == '0) ? PH_CODE : PH_A_SKIP;
            end else begin
              audio_total_next = audio_total + effective_size;
              if (field_word == '0) begin
                if (effective_size > field_word) begin
                  r0       = '0;
                  r0.kind  = K_PAD;
                  r0.count = effective_size - field_word;
                  n_res    = 2'd1;
                end
                phase_next = PH_CODE;
              end else begin
                phase_next = PH_AUDIO;
              end
            end
            code_lo_next = '0;
          end
        end
        PH_AUDIO: begin
          r0              = byte_res(K_AUDIO, b);
          n_res           = 2'd1;
          bytes_left_next = bytes_left - 32'd1;
          if (count_done) begin
            // a short audio chunk is topped up with a zero run
            if (effective_size > payload_size) begin
              r1       = '0;
              r1.kind  = K_PAD;
              r1.count = effective_size - payload_size;
              n_res    = 2'd2;
            end
            phase_next    = PH_CODE;
            code_lo_next  = '0;
            byte_idx_next = '0;
          end
        end
        PH_V_SIZE: begin
          payload_size_next = field_word;
          byte_idx_next     = byte_idx + 2'd1;
          if (field_done) begin
            phase_next      = PH_V_SKIP;
            bytes_left_next = VID_SKIP;
          end
        end
        PH_V_SKIP: begin
          bytes_left_next = bytes_left - 32'd1;
          if (count_done) begin
            phase_next      = PH_V_HEAD;
            bytes_left_next = VID_HEAD;
          end
        end
        PH_V_HEAD: begin
          r0              = byte_res(K_HEAD, b);
          n_res           = 2'd1;
          bytes_left_next = bytes_left - 32'd1;
          if (count_done) begin
            // body is whatever the size gives beyond the head part
            if (payload_size > VID_HEAD) begin
              bytes_left_next = payload_size - VID_HEAD;
              phase_next      = PH_BODY;
            end else begin
              bytes_left_next = '0;
              phase_next      = PH_CODE;
              code_lo_next    = '0;
              byte_idx_next   = '0;
            end
          end
        end
        PH_F_SIZE: begin
          r0                = byte_res(K_HEAD, b);
          n_res             = 2'd1;
          payload_size_next = field_word;
          byte_idx_next     = byte_idx + 2'd1;
          if (field_done) begin
            phase_next      = PH_F_SKIP;
            bytes_left_next = FRM_SKIP;
          end
        end
        PH_F_SKIP: begin
          bytes_left_next = bytes_left - 32'd1;
          if (count_done) begin
            bytes_left_next = payload_size;
            if (payload_size == '0) begin
              phase_next    = PH_CODE;
              code_lo_next  = '0;
              byte_idx_next = '0;
            end else begin
              phase_next = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          r0              = byte_res(K_BODY, b);
          n_res           = 2'd1;
          bytes_left_next = bytes_left - 32'd1;
          if (count_done) begin
            phase_next    = PH_CODE;
            code_lo_next  = '0;
            byte_idx_next = '0;
          end
        end
        PH_A_SKIP, PH_SKIP: begin
          bytes_left_next = bytes_left - 32'd1;
          if (count_done) begin
            phase_next    = PH_CODE;
            code_lo_next  = '0;
            byte_idx_next = '0;
          end
        end
        default: phase_next = PH_HALT;
      endcase
    end

    if (n_res == 2'd1) r0.last = 1'b1;
    if (n_res == 2'd2) r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR;
      file_offset    <= '0;
      code_lo        <= '0;
      byte_idx       <= '0;
      bytes_left     <= '0;
      effective_size <= '0;
      payload_size   <= '0;
      audio_total    <= '0;
      frame_total    <= '0;
      seen_segment   <= 1'b0;
      audio_rate     <= '0;
      audio_chans    <= '0;
      audio_bits     <= '0;
      pic_width      <= '0;
      pic_height     <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      file_offset    <= file_offset_next;
      code_lo        <= code_lo_next;
      byte_idx       <= byte_idx_next;
      bytes_left     <= bytes_left_next;
      effective_size <= effective_size_next;
      payload_size   <= payload_size_next;
      audio_total    <= audio_total_next;
      frame_total    <= frame_total_next;
      seen_segment   <= seen_segment_next;
      audio_rate     <= audio_rate_next;
      audio_chans    <= audio_chans_next;
      audio_bits     <= audio_bits_next;
      pic_width      <= pic_width_next;
      pic_height     <= pic_height_next;
    end
  end

  // output queue, room for two results is needed to take a byte
  assign n_push    = accept ? n_res : 2'd0;
  assign wr_ptr_p1 = wr_ptr + PTR_W'(1);
  assign s_tready  = (cnt <= CNT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) queue[wr_ptr]    <= r0;
    if (n_push == 2'd2) queue[wr_ptr_p1] <= r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      cnt <= cnt + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

  assign m_tvalid = (cnt != '0);
  assign m_tuser  = queue[rd_ptr].kind;
  assign m_tlast  = queue[rd_ptr].last;
  assign m_tdata  = {queue[rd_ptr].pic_height, queue[rd_ptr].pic_width,
                     queue[rd_ptr].audio_bits, queue[rd_ptr].audio_chans,
                     queue[rd_ptr].audio_rate, queue[rd_ptr].frames,
                     queue[rd_ptr].count, queue[rd_ptr].data_byte};

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(QUEUE_DEPTH))
    else $error("output queue overfilled");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_HALT) |=> cnt <= $past(cnt))
    else $error("result produced after halt");

  a_code_err_pair: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == K_CODE_ERR) |-> !m_tlast)
    else $error("code error not followed by end result");

endmodule

// File: sim/av_container_chunk_demux_test.sv
`timescale 1ns / 100ps

module av_container_chunk_demux_test;
  import avcd_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS = 980;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef enum logic [3:0] {
    P_HDR, P_CODE, P_A_IDX, P_A_EFF, P_A_DATA, P_AUDIO, P_A_SKIP,
    P_V_SIZE, P_V_SKIP, P_V_HEAD, P_F_SIZE, P_F_SKIP, P_BODY, P_SKIP, P_HALT
  } parse_phase_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;   // in_byte
  logic                  s_tlast;   // end_of_file
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // data_byte, count, frames, audio_rate,
                                    // audio_chans, audio_bits, pic_width, pic_height
  logic [3:0]            m_tuser;   // kind
  logic                  m_tlast;   // last

  av_container_chunk_demux i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  parse_phase_t parse_ph;
  logic [7:0]   hdr_ofs;
  logic [15:0]  code_acc;
  logic [31:0]  shift_acc;
  logic [31:0]  remain;
  logic [31:0]  eff_size;
  logic [31:0]  data_size;
  logic [31:0]  audio_sum;
  logic [31:0]  frame_cnt;
  logic         seg_open;
  logic [15:0]  meta_rate;
  logic [7:0]   meta_chans;
  logic [7:0]   meta_bits;
  logic [15:0]  meta_width;
  logic [15:0]  meta_height;

  res_t step_q[$];
  res_t pending_results[$];

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned sink_hold = 0;
  logic        src_steady = 1'b0;
  logic        sink_steady = 1'b0;

  logic [15:0] skip_codes [6] = '{CODE_SKIP_A, CODE_SKIP_B, CODE_SKIP_C,
                                  CODE_SKIP_D, CODE_SKIP_E, CODE_SKIP_F};

  // handshakes sampled mid-cycle, stable across the next rising edge
  logic       byte_taken = 1'b0;
  logic       res_taken = 1'b0;
  logic [7:0] taken_byte;
  logic       taken_eof;
  res_t       taken_res;

  always @(negedge clk) begin
    byte_taken <= s_tvalid && s_tready;
    res_taken  <= m_tvalid && m_tready;
    taken_byte <= s_tdata;
    taken_eof  <= s_tlast;
    taken_res  <= {m_tlast, m_tdata[135:120], m_tdata[119:104], m_tdata[103:96],
                   m_tdata[95:88], m_tdata[87:72], m_tdata[71:40], m_tdata[39:8],
                   m_tdata[7:0], m_tuser};
  end

  function automatic res_t blank_res(input kind_t k);
    res_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic res_t totals_res(input kind_t k);
    res_t r;
    r = blank_res(k);
    r.count = audio_sum;
    r.frames = frame_cnt;
    return r;
  endfunction

  function automatic string res_text(input res_t r);
    return $sformatf("kind %0d data %h count %h frames %h rate %h ch %h bits %h w %h h %h last %b",
                     r.kind, r.data_byte, r.count, r.frames, r.audio_rate, r.audio_chans,
                     r.audio_bits, r.pic_width, r.pic_height, r.last);
  endfunction

  task automatic to_code();
    parse_ph = P_CODE;
    code_acc = '0;
    shift_acc = '0;
  endtask

  task automatic take_le32(inout logic [31:0] dst, input logic [7:0] b, output logic done);
    dst = dst | (32'(b) << (shift_acc & 32'd31));
    shift_acc = shift_acc + 32'd8;
    done = (shift_acc >= 32'd32);
    if (done) shift_acc = '0;
  endtask

  task automatic pad_if_short();
    res_t r;
    if (eff_size > data_size) begin
      r = blank_res(K_PAD);
      r.count = eff_size - data_size;
      step_q.push_back(r);
    end
  endtask

  task automatic finish_code();
    case (code_acc)
      CODE_AUDIO: begin
        parse_ph = P_A_IDX;
        shift_acc = '0;
      end
      CODE_VHDR: begin
        if (seg_open) begin
          step_q.push_back(totals_res(K_SEGMENT));
          audio_sum = '0;
        end
        frame_cnt = '0;
        seg_open = 1'b1;
        parse_ph = P_V_SIZE;
        shift_acc = '0;
        data_size = '0;
      end
      CODE_FRAME: begin
        frame_cnt = frame_cnt + 1;
        parse_ph = P_F_SIZE;
        shift_acc = '0;
        data_size = '0;
      end
      CODE_SKIP_A, CODE_SKIP_B, CODE_SKIP_C, CODE_SKIP_D, CODE_SKIP_E, CODE_SKIP_F: begin
        parse_ph = P_SKIP;
        remain = MISC_SKIP;
      end
      default: begin
        step_q.push_back(blank_res(K_CODE_ERR));
        step_q.push_back(totals_res(K_END));
        parse_ph = P_HALT;
      end
    endcase
  endtask

  task automatic parse_chunk_byte(input logic [7:0] b);
    logic        done;
    logic [31:0] idx;
    idx = '0;
    case (parse_ph)
      P_CODE: begin
        code_acc = code_acc | (16'(b) << (shift_acc & 32'd8));
        if (shift_acc == 0) begin
          shift_acc = 32'd8;
        end else begin
          shift_acc = '0;
          finish_code();
        end
      end
      P_A_IDX: begin
        take_le32(idx, b, done);
        if (done) begin
          parse_ph = P_A_EFF;
          eff_size = '0;
        end
      end
      P_A_EFF: begin
        take_le32(eff_size, b, done);
        if (done) begin
          parse_ph = P_A_DATA;
          data_size = '0;
        end
      end
      P_A_DATA: begin
        take_le32(data_size, b, done);
        if (done) begin
          remain = data_size;
          if (eff_size == 0) begin
            if (remain == 0) to_code();
            else parse_ph = P_A_SKIP;
          end else begin
            audio_sum = audio_sum + eff_size;
            if (remain == 0) begin
              pad_if_short();
              to_code();
            end else begin
              parse_ph = P_AUDIO;
            end
          end
        end
      end
      P_AUDIO: begin
        step_q.push_back(blank_res(K_AUDIO));
        step_q[$].data_byte = b;
        remain = remain - 1;
        if (remain == 0) begin
          pad_if_short();
          to_code();
        end
      end
      P_V_SIZE: begin
        take_le32(data_size, b, done);
        if (done) begin
          parse_ph = P_V_SKIP;
          remain = VID_SKIP;
        end
      end
      P_V_SKIP: begin
        remain = remain - 1;
        if (remain == 0) begin
          parse_ph = P_V_HEAD;
          remain = VID_HEAD;
        end
      end
      P_V_HEAD: begin
        step_q.push_back(blank_res(K_HEAD));
        step_q[$].data_byte = b;
        remain = remain - 1;
        if (remain == 0) begin
          remain = (data_size >= VID_HEAD) ? data_size - VID_HEAD : 32'd0;
          if (remain == 0) to_code();
          else parse_ph = P_BODY;
        end
      end
      P_F_SIZE: begin
        step_q.push_back(blank_res(K_HEAD));
        step_q[$].data_byte = b;
        take_le32(data_size, b, done);
        if (done) begin
          parse_ph = P_F_SKIP;
          remain = FRM_SKIP;
        end
      end
      P_F_SKIP: begin
        remain = remain - 1;
        if (remain == 0) begin
          remain = data_size;
          if (remain == 0) to_code();
          else parse_ph = P_BODY;
        end
      end
      P_BODY: begin
        step_q.push_back(blank_res(K_BODY));
        step_q[$].data_byte = b;
        remain = remain - 1;
        if (remain == 0) to_code();
      end
      P_A_SKIP, P_SKIP: begin
        remain = remain - 1;
        if (remain == 0) to_code();
      end
      default: begin
        parse_ph = P_HALT;
      end
    endcase
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eof);
    res_t r;
    if (parse_ph != P_HALT) begin
      if (eof) begin
        if (parse_ph == P_HDR && hdr_ofs < 4) step_q.push_back(blank_res(K_MAGIC_ERR));
        else step_q.push_back(totals_res(K_END));
        parse_ph = P_HALT;
      end else if (parse_ph == P_HDR) begin
        if (hdr_ofs < 4 && b != MAGIC[hdr_ofs[1:0]*8 +: 8]) begin
          step_q.push_back(blank_res(K_MAGIC_ERR));
          parse_ph = P_HALT;
        end else begin
          case (hdr_ofs)
            OFS_RATE_LO:   meta_rate[7:0] = b;
            OFS_RATE_HI:   meta_rate[15:8] = b;
            OFS_CHANS:     meta_chans = b;
            OFS_BITS:      meta_bits = b;
            OFS_HEIGHT_LO: meta_height[7:0] = b;
            OFS_HEIGHT_HI: meta_height[15:8] = b;
            OFS_WIDTH_LO:  meta_width[7:0] = b;
            OFS_WIDTH_HI:  meta_width[15:8] = b;
            default: ;
          endcase
          if (hdr_ofs >= HDR_LAST) begin
            r = blank_res(K_META);
            r.audio_rate = meta_rate;
            r.audio_chans = meta_chans;
            r.audio_bits = meta_bits;
            r.pic_width = meta_width;
            r.pic_height = meta_height;
            step_q.push_back(r);
            to_code();
          end else begin
            hdr_ofs = hdr_ofs + 1;
          end
        end
      end else begin
        parse_chunk_byte(b);
      end
    end
    if (step_q.size() != 0) begin
      r = step_q.pop_back();
      r.last = 1'b1;
      step_q.push_back(r);
    end
    while (step_q.size() != 0) pending_results.push_back(step_q.pop_front());
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("unexpected result: %s", res_text(got));
    end else begin
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
          got.count !== want.count || got.frames !== want.frames ||
          got.audio_rate !== want.audio_rate || got.audio_chans !== want.audio_chans ||
          got.audio_bits !== want.audio_bits || got.pic_width !== want.pic_width ||
          got.pic_height !== want.pic_height || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result mismatch at %0t", $realtime);
          $display("  expected: %s", res_text(want));
          $display("  actual:   %s", res_text(got));
        end
      end
    end
  endtask

  initial begin
    parse_ph = P_HDR;
    hdr_ofs = '0;
    code_acc = '0;
    shift_acc = '0;
    remain = '0;
    eff_size = '0;
    data_size = '0;
    audio_sum = '0;
    frame_cnt = '0;
    seg_open = 1'b0;
    meta_rate = '0;
    meta_chans = '0;
    meta_bits = '0;
    meta_width = '0;
    meta_height = '0;
  end

  // predict first so a result can never be checked ahead of its cause
  always @(posedge clk) begin
    if (byte_taken) parse_byte(taken_byte, taken_eof);
    if (res_taken) check_result(taken_res);
    if (byte_taken || res_taken) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // sink side, with the long hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_hold != 0) begin
      m_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      m_tready <= sink_steady || ($urandom_range(99) >= 32);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eof);
    while (!src_steady && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eof;
    @(posedge clk);
    while (!byte_taken) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_bytes(input int unsigned n);
    repeat (n) send_item(8'($urandom), 1'b0);
  endtask

  task automatic send_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) send_item(v[8*i +: 8], 1'b0);
  endtask

  task automatic send_code(input logic [15:0] c);
    send_item(c[7:0], 1'b0);
    send_item(c[15:8], 1'b0);
  endtask

  task automatic send_audio(input logic [31:0] eff, input logic [31:0] len);
    send_code(CODE_AUDIO);
    send_le32($urandom);
    send_le32(eff);
    send_le32(len);
    send_bytes(len);
  endtask

  task automatic send_vhdr(input logic [31:0] size);
    send_code(CODE_VHDR);
    send_le32(size);
    send_bytes(VID_SKIP);
    send_bytes(VID_HEAD);
    if (size > VID_HEAD) send_bytes(size - VID_HEAD);
  endtask

  task automatic send_frame(input logic [31:0] size);
    send_code(CODE_FRAME);
    send_le32(size);
    send_bytes(FRM_SKIP);
    send_bytes(size);
  endtask

  task automatic send_skip(input logic [15:0] c);
    send_code(c);
    send_bytes(MISC_SKIP);
  endtask

  task automatic send_random_chunk();
    int unsigned sel;
    logic [31:0] len;
    logic [31:0] eff;
    sel = $urandom_range(99);
    if (sel < 35) begin
      len = $urandom_range(0, 12);
      case ($urandom_range(3))
        0: eff = '0;
        1: eff = len;
        2: eff = len + $urandom_range(1, 40);
        default: eff = $urandom;
      endcase
      send_audio(eff, len);
    end else if (sel < 65) begin
      send_frame($urandom_range(0, 16));
    end else if (sel < 75) begin
      send_vhdr($urandom_range(0, VID_HEAD + 16));
    end else begin
      send_skip(skip_codes[$urandom_range(5)]);
    end
  endtask

  task automatic test_header_capture();
    logic [7:0] b;
    for (int i = 0; i <= HDR_LAST; i++) begin
      if (i < 4) begin
        b = MAGIC[8*i +: 8];
      end else if (i >= OFS_RATE_LO && i <= OFS_WIDTH_HI) begin
        case ($urandom_range(2))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = 8'($urandom);
        endcase
      end else begin
        b = 8'($urandom);
      end
      send_item(b, 1'b0);
    end
  endtask

  task automatic test_audio_chunks();
    send_audio(32'd10, 32'd4);          // pad run after the data
    send_audio(32'd3, 32'd3);
    send_audio(32'd2, 32'd5);           // effective shorter than data
    send_audio(32'd0, 32'd3);           // zero effective size, data dropped
    send_audio(32'd0, 32'd0);
    send_audio(32'd7, 32'd0);           // pad with no data bytes
    send_audio(32'hFFFF_FFF0, 32'd2);   // audio total wraps
  endtask

  task automatic test_video_chunks();
    send_vhdr(32'd10);                  // first header, short size
    send_frame(32'd0);
    send_frame(32'd3);
    send_vhdr(VID_HEAD);                // closes the first segment
    send_audio(32'd5, 32'd5);
    send_vhdr(VID_HEAD + 4);
  endtask

  task automatic test_skip_codes();
    foreach (skip_codes[i]) send_skip(skip_codes[i]);
  endtask

  task automatic test_output_stall();
    src_steady = 1'b1;
    sink_hold = HOLD_CYCLES;
    send_audio(32'd40, 32'd40);
    src_steady = 1'b0;
  endtask

  task automatic test_random_stream();
    int unsigned start;
    start = items_sent;
    while (items_sent < start + RANDOM_ITEMS) begin
      src_steady = (items_sent >= start + 600) && (items_sent < start + 900);
      sink_steady = src_steady;
      send_random_chunk();
    end
    src_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  task automatic test_stream_end();
    logic [15:0] code;
    case ($urandom_range(2))
      0: begin
        send_item(8'($urandom), 1'b1);
      end
      1: begin
        // end of file after a frame code, its size and up to twelve further bytes
        send_code(CODE_FRAME);
        send_le32($urandom_range(1, 20));
        send_bytes($urandom_range(0, 12));
        send_item(8'($urandom), 1'b1);
      end
      default: begin
        do begin
          code = $urandom_range(1) ? {8'h00, 8'($urandom)} : 16'($urandom);
        end while (code == CODE_AUDIO || code == CODE_VHDR || code == CODE_FRAME ||
                   code == CODE_SKIP_A || code == CODE_SKIP_B || code == CODE_SKIP_C ||
                   code == CODE_SKIP_D || code == CODE_SKIP_E || code == CODE_SKIP_F);
        send_code(code);
      end
    endcase
    // the block is halted now and must stay silent
    repeat (4) send_item(8'($urandom), 1'($urandom_range(1)));
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_header_capture();
    test_audio_chunks();
    test_video_chunks();
    test_skip_codes();
    test_output_stall();
    test_random_stream();
    test_stream_end();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
